/* sv/apc_pkg.sv */
// Shared constants, codes and widths for the audio playout prebuffer controller.
`default_nettype none
package apc_pkg;

    localparam int RING_DEPTH    = 32768;
    localparam int CHUNK_SAMPLES = 32;
    localparam int LEVEL_STEP    = 4;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int IDX_W  = $clog2(CHUNK_SAMPLES);
    localparam int N_W    = $clog2(CHUNK_SAMPLES + 1);

    localparam int CNT_MAX = (CHUNK_SAMPLES + LEVEL_STEP - 1) / LEVEL_STEP;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = 16 + $clog2(CNT_MAX);

    // The divider covers both the mean and the scaled mean (mean * 255 < 2**23).
    localparam int DIV_W  = 23;
    localparam int DIVR_W = 16;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam int APB_AW = 4;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_DRAIN  = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_CREDIT = 2'd3;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_CREDIT = 2'd2;

    localparam logic [1:0] REG_PREBUF_LEVEL = 2'd0;
    localparam logic [1:0] REG_PREBUF_WAIT  = 2'd1;
    localparam logic [1:0] REG_END_PASSES   = 2'd2;
    localparam logic [1:0] REG_FULL_SCALE   = 2'd3;

    localparam logic [15:0] RST_PREBUF_LEVEL = 16'd3200;
    localparam logic [4:0]  RST_PREBUF_WAIT  = 5'd15;
    localparam logic [4:0]  RST_END_PASSES   = 5'd15;
    localparam logic [15:0] RST_FULL_SCALE   = 16'd6000;

    localparam logic [4:0] HELD_MAX  = 5'd31;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

endpackage
`default_nettype wire

/* sv/apc_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, used for the loudness level.
`default_nettype none
module apc_div
    import apc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dvsr_reg, dvsr_next;

    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W+1:0] diff;

    always_comb begin
        rem_sh    = {rem_reg, quot_reg[DIV_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (busy_reg) begin
            if (!diff[DIVR_W+1]) begin
                rem_next  = diff[DIVR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[DIVR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W - 1);
            quot_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

/* sv/audio_playout_prebuffer_controller.sv */
// Top level of the audio playout prebuffer controller: sample FIFO, playout control, level.
`default_nettype none
// The block queues PCM16 samples in a 32768-entry single-port sample memory and plays them
// out in chunks of up to 32 items per drain pass, holding back playback until the prebuffer
// level or the wait limit is reached. Every input item passes through an accept and an
// execute state, and waits in execute while the result register is still occupied. A drain
// pass does one memory read and one output per sample, and runs two bit-serial 23-bit
// divisions that produce the loudness level before the last sample leaves; a silence chunk
// gives 32 samples. Write, flush and credit items give one result or none. No clearing pass
// is run after reset: only written entries are read.
module audio_playout_prebuffer_controller
    import apc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // s_tdata: sample[15:0]
    input  wire logic [15:0]       s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // m_tdata: out_sample[15:0], accepted[16], playing[17], started[18], ended[19],
    // level[27:20], level_valid[28], credit[60:29], zero fill[63:61]
    output logic [63:0]            m_tdata,
    // m_tuser: kind[1:0]
    output logic [1:0]             m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_EXEC = 9'b000000010,
        ST_SIL  = 9'b000000100,
        ST_RD   = 9'b000001000,
        ST_EMIT = 9'b000010000,
        ST_DIV1 = 9'b000100000,
        ST_DIV2 = 9'b001000000,
        ST_LAST = 9'b010000000,
        ST_SPARE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] cfg_level_reg;
    logic [4:0]  cfg_wait_reg;
    logic [4:0]  cfg_end_reg;
    logic [15:0] cfg_fs_reg;

    logic [1:0]  cmd_mode_reg, cmd_mode_next;
    logic [15:0] cmd_sample_reg, cmd_sample_next;

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              playing_reg, playing_next;
    logic [4:0]        held_reg, held_next;
    logic [4:0]        dry_reg, dry_next;
    logic              refill_reg, refill_next;
    logic [31:0]       credit_reg, credit_next;

    logic              started_reg, started_next;
    logic              ended_reg, ended_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        level_reg, level_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [15:0] out_sample_reg, out_sample_next;
    logic        out_last_reg, out_last_next;
    logic        out_acc_reg, out_acc_next;
    logic        out_play_reg, out_play_next;
    logic        out_start_reg, out_start_next;
    logic        out_end_reg, out_end_next;
    logic [7:0]  out_level_reg, out_level_next;
    logic        out_lvalid_reg, out_lvalid_next;
    logic [31:0] out_credit_reg, out_credit_next;

    logic [15:0]      mem [RING_DEPTH];
    logic [15:0]      rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    logic cfg_wr;
    logic out_free;

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [N_W-1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(k);
        if (s >= (PTR_W + 1)'(RING_DEPTH)) begin
            s = s - (PTR_W + 1)'(RING_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [31:0] credit_add(input logic [31:0] c,
                                               input logic [FILL_W-1:0] k);
        logic [32:0] s;
        s = {1'b0, c} + 33'(k);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        case (paddr[3:2])
            REG_PREBUF_LEVEL: prdata = {16'd0, cfg_level_reg};
            REG_PREBUF_WAIT:  prdata = {27'd0, cfg_wait_reg};
            REG_END_PASSES:   prdata = {27'd0, cfg_end_reg};
            REG_FULL_SCALE:   prdata = {16'd0, cfg_fs_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_level_reg <= RST_PREBUF_LEVEL;
            cfg_wait_reg  <= RST_PREBUF_WAIT;
            cfg_end_reg   <= RST_END_PASSES;
            cfg_fs_reg    <= RST_FULL_SCALE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PREBUF_LEVEL: cfg_level_reg <= pwdata[15:0];
                REG_PREBUF_WAIT:  cfg_wait_reg  <= pwdata[4:0];
                REG_END_PASSES:   cfg_end_reg   <= pwdata[4:0];
                REG_FULL_SCALE:   cfg_fs_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic             play_v;
        logic             start_v;
        logic             end_v;
        logic             ready_v;
        logic             sil_v;
        logic [4:0]       dry_v;
        logic [4:0]       held_v;
        logic             take_v;
        logic [15:0]      abs_v;
        logic [SUM_W-1:0] sum_acc;
        logic [CNT_W-1:0] cnt_acc;
        logic [23:0]      prod_v;
        logic             emit;
        logic [1:0]       e_kind;
        logic [15:0]      e_sample;
        logic             e_last;
        logic             e_acc;
        logic             e_start;
        logic             e_end;
        logic [7:0]       e_level;
        logic             e_lvalid;
        logic [31:0]      e_credit;

        state_next      = state_reg;
        cmd_mode_next   = cmd_mode_reg;
        cmd_sample_next = cmd_sample_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        playing_next    = playing_reg;
        held_next       = held_reg;
        dry_next        = dry_reg;
        refill_next     = refill_reg;
        credit_next     = credit_reg;
        started_next    = started_reg;
        ended_next      = ended_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        level_next      = level_reg;

        m_valid_next    = m_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_acc_next    = out_acc_reg;
        out_play_next   = out_play_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_level_next  = out_level_reg;
        out_lvalid_next = out_lvalid_reg;
        out_credit_next = out_credit_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = ptr_add(rp_reg, N_W'(idx_reg));

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        play_v  = playing_reg;
        start_v = 1'b0;
        end_v   = 1'b0;
        ready_v = 1'b0;
        sil_v   = 1'b0;
        dry_v   = dry_reg;
        held_v  = held_reg;

        take_v  = ((idx_reg % LEVEL_STEP) == 0);
        abs_v   = rd_data_reg[15] ? (~rd_data_reg + 16'd1) : rd_data_reg;
        sum_acc = sum_reg + (take_v ? SUM_W'(abs_v) : '0);
        cnt_acc = cnt_reg + (take_v ? CNT_W'(1) : '0);
        prod_v  = {div_quot[15:0], 8'd0} - {8'd0, div_quot[15:0]};

        emit     = 1'b0;
        e_kind   = KIND_SAMPLE;
        e_sample = 16'd0;
        e_last   = 1'b0;
        e_acc    = 1'b0;
        e_start  = 1'b0;
        e_end    = 1'b0;
        e_level  = 8'd0;
        e_lvalid = 1'b0;
        e_credit = 32'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_mode_next   = s_tuser;
                    cmd_sample_next = s_tdata;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    case (cmd_mode_reg)
                        MODE_WRITE: begin
                            emit   = 1'b1;
                            e_kind = KIND_ACK;
                            e_last = 1'b1;
                            if (fill_reg < FILL_W'(RING_DEPTH)) begin
                                mem_we    = 1'b1;
                                wp_next   = ptr_add(wp_reg, N_W'(1));
                                fill_next = fill_reg + 1'b1;
                                e_acc     = 1'b1;
                            end
                        end
                        MODE_FLUSH: begin
                            credit_next = credit_add(credit_reg, fill_reg);
                            fill_next   = '0;
                            rp_next     = wp_reg;
                            refill_next = 1'b1;
                        end
                        MODE_CREDIT: begin
                            emit        = 1'b1;
                            e_kind      = KIND_CREDIT;
                            e_last      = 1'b1;
                            e_credit    = credit_reg;
                            credit_next = 32'd0;
                        end
                        default: begin
                            if (refill_reg) begin
                                refill_next = 1'b0;
                                if (play_v) begin
                                    play_v = 1'b0;
                                    end_v  = 1'b1;
                                end
                                dry_v = 5'd0;
                            end
                            if (!play_v) begin
                                ready_v = (fill_reg >= FILL_W'(cfg_level_reg)) ||
                                          ((fill_reg != '0) && (held_v >= cfg_wait_reg));
                                if (!ready_v) begin
                                    if ((fill_reg != '0) && (held_v != HELD_MAX)) begin
                                        held_v = held_v + 5'd1;
                                    end
                                    sil_v = 1'b1;
                                end else begin
                                    held_v  = 5'd0;
                                    dry_v   = 5'd0;
                                    play_v  = 1'b1;
                                    start_v = 1'b1;
                                end
                            end
                            if (!sil_v) begin
                                if (fill_reg == '0) begin
                                    dry_v = dry_v + 5'd1;
                                    if (dry_v >= cfg_end_reg) begin
                                        dry_v  = 5'd0;
                                        play_v = 1'b0;
                                        end_v  = 1'b1;
                                    end
                                    sil_v = 1'b1;
                                end else begin
                                    dry_v = 5'd0;
                                    if (fill_reg < FILL_W'(CHUNK_SAMPLES)) begin
                                        n_next = fill_reg[N_W-1:0];
                                    end else begin
                                        n_next = N_W'(CHUNK_SAMPLES);
                                    end
                                end
                            end
                            playing_next = play_v;
                            held_next    = held_v;
                            dry_next     = dry_v;
                            started_next = start_v;
                            ended_next   = end_v;
                            idx_next     = '0;
                            sum_next     = '0;
                            cnt_next     = '0;
                            state_next   = sil_v ? ST_SIL : ST_RD;
                        end
                    endcase
                end
            end
            ST_SIL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_start = started_reg;
                    e_end   = ended_reg;
                    e_last  = (idx_reg == IDX_W'(CHUNK_SAMPLES - 1));
                    idx_next = idx_reg + 1'b1;
                    if (e_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                mem_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (N_W'(idx_reg) == n_reg - 1'b1) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_acc);
                    div_divisor  = DIVR_W'(cnt_acc);
                    state_next   = ST_DIV1;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_sample   = rd_data_reg;
                    e_start    = started_reg;
                    e_end      = ended_reg;
                    sum_next   = sum_acc;
                    cnt_next   = cnt_acc;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = prod_v[DIV_W-1:0];
                    div_divisor  = (cfg_fs_reg == 16'd0) ? 16'd1 : cfg_fs_reg;
                    state_next   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    level_next = (|div_quot[DIV_W-1:8]) ? LEVEL_MAX : div_quot[7:0];
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    emit        = 1'b1;
                    e_sample    = rd_data_reg;
                    e_start     = started_reg;
                    e_end       = ended_reg;
                    e_last      = 1'b1;
                    e_level     = level_reg;
                    e_lvalid    = 1'b1;
                    rp_next     = ptr_add(rp_reg, n_reg);
                    fill_next   = fill_reg - FILL_W'(n_reg);
                    credit_next = credit_add(credit_reg, FILL_W'(n_reg));
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next    = 1'b1;
            out_kind_next   = e_kind;
            out_sample_next = e_sample;
            out_last_next   = e_last;
            out_acc_next    = e_acc;
            out_play_next   = playing_reg;
            out_start_next  = e_start;
            out_end_next    = e_end;
            out_level_next  = e_level;
            out_lvalid_next = e_lvalid;
            out_credit_next = e_credit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rp_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            playing_reg <= 1'b0;
            held_reg    <= '0;
            dry_reg     <= '0;
            refill_reg  <= 1'b0;
            credit_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            playing_reg <= playing_next;
            held_reg    <= held_next;
            dry_reg     <= dry_next;
            refill_reg  <= refill_next;
            credit_reg  <= credit_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_mode_reg   <= cmd_mode_next;
        cmd_sample_reg <= cmd_sample_next;
        started_reg    <= started_next;
        ended_reg      <= ended_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        level_reg      <= level_next;
        out_kind_reg   <= out_kind_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_acc_reg    <= out_acc_next;
        out_play_reg   <= out_play_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_level_reg  <= out_level_next;
        out_lvalid_reg <= out_lvalid_next;
        out_credit_reg <= out_credit_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= cmd_sample_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    apc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_credit_reg, out_lvalid_reg, out_level_reg, out_end_reg,
                       out_start_reg, out_play_reg, out_acc_reg, out_sample_reg};

endmodule
`default_nettype wire

/* tb/tb_audio_playout_prebuffer_controller.sv */
// Self-checking testbench: drives sample, pass, flush and credit items and checks every result.
`timescale 1ns / 1ps
module tb_audio_playout_prebuffer_controller
    import apc_pkg::*;
();

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] sample;
    } host_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] smp;
        logic        last;
        logic        acc;
        logic        playing;
        logic        started;
        logic        ended;
        logic [7:0]  level;
        logic        lvalid;
        logic [31:0] credit;
    } playout_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic [15:0]       s_tdata = '0;
    logic [1:0]        s_tuser = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    host_item_t      host_items_q[$];
    playout_result_t playout_due_q[$];
    host_item_t      offered;
    int              items_sent = 0;
    int              items_taken = 0;
    int              mismatches = 0;
    int              idle_pct = 15;
    int              gap_left = 0;
    int              stall_left = 0;
    int              hold_left = 0;
    bit              hold_ask = 1'b0;

    logic [15:0] sample_ring [RING_DEPTH];
    int          rd_ptr = 0;
    int          wr_ptr = 0;
    int          fill = 0;
    int          dry_cnt = 0;
    logic [4:0]  held_cnt = '0;
    logic        play_on = 1'b0;
    logic        refill_due = 1'b0;
    logic [31:0] freed = '0;
    logic [15:0] cfg_level = RST_PREBUF_LEVEL;
    logic [4:0]  cfg_wait = RST_PREBUF_WAIT;
    logic [4:0]  cfg_end = RST_END_PASSES;
    logic [15:0] cfg_fs = RST_FULL_SCALE;

    audio_playout_prebuffer_controller uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void add_result(logic [1:0] kind, logic [15:0] smp, logic last,
                                       logic acc, logic started, logic ended,
                                       logic [7:0] level, logic lvalid, logic [31:0] credit);
        playout_result_t r;
        r.kind = kind;
        r.smp = smp;
        r.last = last;
        r.acc = acc;
        r.playing = play_on;
        r.started = started;
        r.ended = ended;
        r.level = level;
        r.lvalid = lvalid;
        r.credit = credit;
        playout_due_q.push_back(r);
    endfunction

    function automatic void emit_silence(logic started, logic ended);
        for (int i = 0; i < CHUNK_SAMPLES; i++)
            add_result(KIND_SAMPLE, '0, i == CHUNK_SAMPLES - 1, 1'b0, started, ended,
                       '0, 1'b0, '0);
    endfunction

    function automatic void add_credit(int n);
        longint unsigned total;
        total = longint'(freed) + longint'(n);
        freed = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    function automatic void predict_playout(host_item_t it);
        logic        started_now;
        logic        ended_now;
        logic        ready;
        logic [15:0] v;
        int          n;
        int unsigned sum;
        int unsigned cnt;
        int unsigned mean;
        int unsigned scaled;
        int unsigned fs;
        started_now = 1'b0;
        ended_now = 1'b0;
        case (it.mode)
            MODE_WRITE: begin
                if (fill >= RING_DEPTH) begin
                    add_result(KIND_ACK, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
                end else begin
                    sample_ring[wr_ptr] = it.sample;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                    fill++;
                    add_result(KIND_ACK, '0, 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0);
                end
            end
            MODE_DRAIN: begin
                if (refill_due) begin
                    refill_due = 1'b0;
                    if (play_on) begin
                        play_on = 1'b0;
                        ended_now = 1'b1;
                    end
                    dry_cnt = 0;
                end
                if (!play_on) begin
                    ready = (fill >= cfg_level) || (fill > 0 && held_cnt >= cfg_wait);
                    if (!ready) begin
                        if (fill > 0 && held_cnt < HELD_MAX)
                            held_cnt++;
                        emit_silence(1'b0, ended_now);
                        return;
                    end
                    held_cnt = '0;
                    dry_cnt = 0;
                    play_on = 1'b1;
                    started_now = 1'b1;
                end
                if (fill == 0) begin
                    dry_cnt++;
                    if (dry_cnt >= cfg_end) begin
                        dry_cnt = 0;
                        play_on = 1'b0;
                        ended_now = 1'b1;
                    end
                    emit_silence(started_now, ended_now);
                    return;
                end
                dry_cnt = 0;
                n = (fill < CHUNK_SAMPLES) ? fill : CHUNK_SAMPLES;
                sum = 0;
                cnt = 0;
                for (int i = 0; i < n; i++) begin
                    if (i % LEVEL_STEP == 0) begin
                        v = sample_ring[(rd_ptr + i) % RING_DEPTH];
                        sum += v[15] ? (32'h10000 - {16'h0, v}) : {16'h0, v};
                        cnt++;
                    end
                end
                mean = sum / cnt;
                fs = (cfg_fs != 0) ? cfg_fs : 1;
                scaled = mean * 255 / fs;
                if (scaled > LEVEL_MAX)
                    scaled = LEVEL_MAX;
                for (int i = 0; i < n; i++) begin
                    v = sample_ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    add_result(KIND_SAMPLE, v, i == n - 1, 1'b0, started_now, ended_now,
                               (i == n - 1) ? scaled[7:0] : 8'h0, i == n - 1, '0);
                end
                fill -= n;
                add_credit(n);
            end
            MODE_FLUSH: begin
                add_credit(fill);
                fill = 0;
                rd_ptr = wr_ptr;
                refill_due = 1'b1;
            end
            default: begin
                add_result(KIND_CREDIT, '0, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0, freed);
                freed = '0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_playout(offered);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (host_items_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(1, 19) - 1;
                    s_tvalid <= 1'b0;
                end else if (host_items_q.size() != 0) begin
                    offered = host_items_q.pop_front();
                    s_tdata <= offered.sample;
                    s_tuser <= offered.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 400;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        playout_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (playout_due_q.size() == 0) begin
                $display("%0t: unexpected result, kind %0h data %0h", $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = playout_due_q.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("out_sample", want.smp, m_tdata[15:0]);
                check_field("last", want.last, m_tlast);
                check_field("accepted", want.acc, m_tdata[16]);
                check_field("playing", want.playing, m_tdata[17]);
                check_field("started", want.started, m_tdata[18]);
                check_field("ended", want.ended, m_tdata[19]);
                check_field("level", want.level, m_tdata[27:20]);
                check_field("level_valid", want.lvalid, m_tdata[28]);
                check_field("credit", want.credit, m_tdata[60:29]);
            end
        end
    end

    task automatic send(logic [1:0] mode, logic [15:0] sample);
        host_item_t it;
        it.mode = mode;
        it.sample = sample;
        host_items_q.push_back(it);
        items_sent++;
    endtask

    task automatic settle();
        do
            @(posedge aclk);
        while (items_taken != items_sent || playout_due_q.size() != 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PREBUF_LEVEL: cfg_level = value[15:0];
            REG_PREBUF_WAIT:  cfg_wait = value[4:0];
            REG_END_PASSES:   cfg_end = value[4:0];
            default:          cfg_fs = value[15:0];
        endcase
    endtask

    task automatic apply_setup(int level, int wait_passes, int end_count, int full_scale);
        apb_write(REG_PREBUF_LEVEL, level);
        apb_write(REG_PREBUF_WAIT, wait_passes);
        apb_write(REG_END_PASSES, end_count);
        apb_write(REG_FULL_SCALE, full_scale);
    endtask

    initial begin : stimulus
        int n;
        int k;
        int lvl;
        int fs;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: credit starts at zero and an empty pass waits in silence.
        send(MODE_CREDIT, 16'h0000);
        send(MODE_DRAIN, 16'hFFFF);
        settle();

        // Zero end passes and zero full scale, then a flush while playing.
        apply_setup(4, 2, 0, 0);
        send(MODE_WRITE, 16'h7FFF);
        send(MODE_WRITE, 16'h8000);
        send(MODE_WRITE, 16'h0000);
        send(MODE_WRITE, 16'hFFFF);
        send(MODE_WRITE, 16'h0001);
        send(MODE_DRAIN, 16'h0000);
        send(MODE_DRAIN, 16'h0000);
        send(MODE_FLUSH, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        repeat (3) send(MODE_WRITE, pick_sample());
        repeat (3) send(MODE_DRAIN, 16'h0000);
        send(MODE_WRITE, 16'h1234);
        send(MODE_FLUSH, 16'h0000);
        send(MODE_DRAIN, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        settle();

        // Zero prebuffer level: an empty pass starts and ends playback at once.
        apply_setup(0, 0, 1, 32768);
        send(MODE_DRAIN, 16'h0000);
        repeat (4) send(MODE_WRITE, 16'h8000);
        send(MODE_DRAIN, 16'h0000);
        send(MODE_DRAIN, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 3))
                0: lvl = 0;
                1: lvl = 32768;
                default: lvl = $urandom_range(1, 48);
            endcase
            case ($urandom_range(0, 3))
                0: fs = 1;
                1: fs = 32768;
                2: fs = 0;
                default: fs = $urandom_range(2, 8000);
            endcase
            apply_setup(lvl, ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(0, 4),
                        ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(0, 4), fs);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 30;
            endcase
            if (phase == 0) begin
                idle_pct = 15;
                hold_ask = 1'b1;
                repeat (48) send(MODE_WRITE, pick_sample());
                send(MODE_DRAIN, 16'h0000);
            end
            n = 0;
            while (n < 50) begin
                if ($urandom_range(0, 99) < 80) begin
                    k = $urandom_range(1, 40);
                    repeat (k) send(MODE_WRITE, pick_sample());
                    n += k;
                    if ($urandom_range(0, 5) == 0) begin
                        send(MODE_FLUSH, 16'($urandom));
                        n++;
                    end
                    k = $urandom_range(1, 3);
                    repeat (k) send(MODE_DRAIN, 16'($urandom));
                    n += k;
                    if ($urandom_range(0, 3) == 0) begin
                        send(MODE_CREDIT, 16'($urandom));
                        n++;
                    end
                end else begin
                    send(2'($urandom_range(0, 3)), 16'($urandom));
                    n++;
                end
            end
            settle();
        end

        // Largest settings: the wait counter runs to its limit, then a short run is queued.
        idle_pct = 0;
        apply_setup(32768, 31, 31, 32768);
        send(MODE_FLUSH, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        send(MODE_WRITE, 16'h8001);
        repeat (34) send(MODE_DRAIN, 16'h0000);
        send(MODE_FLUSH, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        repeat (8) send(MODE_WRITE, 16'($urandom));
        send(MODE_DRAIN, 16'h0000);
        send(MODE_WRITE, 16'h7FFF);
        send(MODE_FLUSH, 16'h0000);
        send(MODE_CREDIT, 16'h0000);
        send(MODE_DRAIN, 16'h0000);
        settle();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
